/* design/jump_commitment_interlock_fsm_defines.svh */
// ----------------------------------------------------------------------------
// Jump commitment interlock assertion macros
// Shared property shorthands for the interlock checker.
// ----------------------------------------------------------------------------
`ifndef JUMP_COMMITMENT_INTERLOCK_FSM_DEFINES_SVH
`define JUMP_COMMITMENT_INTERLOCK_FSM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JCI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/jci_pkg.sv */
// ----------------------------------------------------------------------------
// Jump commitment interlock package
// Phase, scope, event and reason codes and the types shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jci_pkg;

  // Width of the tag fields on the input channel.
  localparam int EV_TAG_W         = 32;
  localparam int TAG_BITS_DEFAULT = 32;

  // Padded channel widths.
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    PH_GROUND    = 3'd0,
    PH_READY     = 3'd1,
    PH_COMMITTED = 3'd2,
    PH_FLIGHT    = 3'd3,
    PH_LANDED    = 3'd4,
    PH_EMERGENCY = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    SC_GROUND    = 2'd0,
    SC_BOUNDARY  = 2'd1,
    SC_EMERGENCY = 2'd2
  } scope_t;

  typedef enum logic [2:0] {
    EV_PUBLISH    = 3'd0,
    EV_WITHDRAW   = 3'd1,
    EV_LOCK       = 3'd2,
    EV_LAUNCH     = 3'd3,
    EV_INVALIDATE = 3'd4,
    EV_LANDING    = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    R_ACCEPTED       = 4'd0,
    R_ID_REQUIRED    = 4'd1,
    R_NOT_LOCKED     = 4'd2,
    R_MISMATCH       = 4'd3,
    R_BAD_IN_HOLD    = 4'd4,
    R_BAD_IN_READY   = 4'd5,
    R_NO_REPLACE     = 4'd6,
    R_BAD_AFTER_LOCK = 4'd7,
    R_NO_REDIRECT    = 4'd8,
    R_EMERGENCY      = 4'd9,
    R_BAD_PHASE      = 4'd10
  } reason_t;

  // What happens to the held tags on a transfer.
  typedef enum logic [1:0] {
    TAG_KEEP  = 2'd0,
    TAG_LOAD  = 2'd1,
    TAG_CLEAR = 2'd2
  } tag_op_t;

  // Result item; the last field sits in the lowest bits.
  typedef struct packed {
    logic    may_publish;
    scope_t  scope;
    phase_t  phase;
    reason_t reason;
    logic    accepted;
  } result_t;

  localparam int RES_W = $bits(result_t);

  typedef struct packed {
    result_t res;
    tag_op_t tag_op;
  } decision_t;

endpackage

/* design/jump_commitment_interlock_fsm.sv */
// ----------------------------------------------------------------------------
// Jump commitment interlock
// Six-phase interlock that vets publish, withdraw, lock, launch, invalidate and landing events.
// ----------------------------------------------------------------------------
// Events arrive on the in_ stream: in_tuser carries the event code and
// in_tdata the bundle and boundary tags with their valid flags. Each event
// transfer produces exactly one result transfer on the out_ stream, carrying
// the verdict, the reason code, the new phase and scope and the publish flag.
// An event is held in an input register, decided against the stored phase
// and held tags, and written to the result register together with the state
// update. A result is offered once its event is in the result register. One
// event per cycle is sustained with out_tready high: the phase and tag update
// is a single registered step, so consecutive events see each other's effect.
// When the receiver holds out_tready low the result register keeps its item
// and an empty input register still takes one more event, after which
// in_tready drops until the result has gone. Reset clears both registers,
// returns the phase to ground hold with ground scope and drops the held tags.
// Emergency delegated is left only through reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jump_commitment_interlock_fsm import jci_pkg::*; #(
  parameter int TAG_BITS = TAG_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // bundle_valid[0], bundle_tag[32:1], boundary_valid[33], boundary_tag[65:34]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd[2:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // accepted[0], reason[4:1], phase_out[7:5], scope_out[9:8], may_publish[10]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int HELD_W = (TAG_BITS < EV_TAG_W) ? TAG_BITS : EV_TAG_W;

  // Input register.
  logic                in_valid_r;
  cmd_t                cmd_r;
  logic                bundle_valid_r;
  logic [EV_TAG_W-1:0] bundle_tag_r;
  logic                boundary_valid_r;
  logic [EV_TAG_W-1:0] boundary_tag_r;

  // Interlock state.
  phase_t              phase_r;
  scope_t              scope_r;
  logic                held_bundle_valid_r;
  logic [HELD_W-1:0]   held_bundle_tag_r;
  logic                held_boundary_valid_r;
  logic [HELD_W-1:0]   held_boundary_tag_r;

  // Result register.
  logic                out_valid_r;
  result_t             out_r;

  decision_t           dec;
  logic                advance;
  logic                in_xfer;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  jci_decide #(
    .HELD_W (HELD_W)
  ) u_decide (
    .phase_i               (phase_r),
    .scope_i               (scope_r),
    .held_bundle_valid_i   (held_bundle_valid_r),
    .held_bundle_tag_i     (held_bundle_tag_r),
    .held_boundary_valid_i (held_boundary_valid_r),
    .held_boundary_tag_i   (held_boundary_tag_r),
    .cmd_i                 (cmd_r),
    .bundle_valid_i        (bundle_valid_r),
    .bundle_tag_i          (bundle_tag_r),
    .boundary_valid_i      (boundary_valid_r),
    .boundary_tag_i        (boundary_tag_r),
    .dec_o                 (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r            <= cmd_t'(in_tuser[2:0]);
      bundle_valid_r   <= in_tdata[0];
      bundle_tag_r     <= in_tdata[32:1];
      boundary_valid_r <= in_tdata[33];
      boundary_tag_r   <= in_tdata[65:34];
    end
  end

  // The state moves with the event as it passes into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r               <= PH_GROUND;
      scope_r               <= SC_GROUND;
      held_bundle_valid_r   <= 1'b0;
      held_bundle_tag_r     <= '0;
      held_boundary_valid_r <= 1'b0;
      held_boundary_tag_r   <= '0;
    end else if (advance && in_valid_r) begin
      phase_r <= dec.res.phase;
      scope_r <= dec.res.scope;
      unique case (dec.tag_op)
        TAG_LOAD: begin
          held_bundle_valid_r   <= 1'b1;
          held_bundle_tag_r     <= bundle_tag_r[HELD_W-1:0];
          held_boundary_valid_r <= 1'b1;
          held_boundary_tag_r   <= boundary_tag_r[HELD_W-1:0];
        end
        TAG_CLEAR: begin
          held_bundle_valid_r   <= 1'b0;
          held_bundle_tag_r     <= '0;
          held_boundary_valid_r <= 1'b0;
          held_boundary_tag_r   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_r <= dec.res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, out_r};

endmodule

/* design/jci_decide.sv */
// ----------------------------------------------------------------------------
// Jump commitment interlock decision logic
// Next phase, scope, tag action and verdict for one event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jci_decide import jci_pkg::*; #(
  parameter int HELD_W = (TAG_BITS_DEFAULT < EV_TAG_W) ? TAG_BITS_DEFAULT : EV_TAG_W
) (
  input  phase_t                phase_i,
  input  scope_t                scope_i,
  input  logic                  held_bundle_valid_i,
  input  logic [HELD_W-1:0]     held_bundle_tag_i,
  input  logic                  held_boundary_valid_i,
  input  logic [HELD_W-1:0]     held_boundary_tag_i,
  input  cmd_t                  cmd_i,
  input  logic                  bundle_valid_i,
  input  logic [EV_TAG_W-1:0]   bundle_tag_i,
  input  logic                  boundary_valid_i,
  input  logic [EV_TAG_W-1:0]   boundary_tag_i,
  output decision_t             dec_o
);

  logic    has_ids;
  logic    bnd_match;
  logic    bun_match;
  logic    both_match;
  logic    acc;
  reason_t reason;
  phase_t  phase_nxt;
  scope_t  scope_nxt;
  tag_op_t tag_op;

  assign has_ids    = bundle_valid_i && boundary_valid_i;
  assign bnd_match  = held_boundary_valid_i && boundary_valid_i &&
                      (held_boundary_tag_i == boundary_tag_i[HELD_W-1:0]);
  assign bun_match  = held_bundle_valid_i && bundle_valid_i &&
                      (held_bundle_tag_i == bundle_tag_i[HELD_W-1:0]);
  assign both_match = bnd_match && bun_match;

  always_comb begin
    acc       = 1'b0;
    reason    = R_BAD_PHASE;
    phase_nxt = phase_i;
    scope_nxt = scope_i;
    tag_op    = TAG_KEEP;
    unique case (phase_i)
      PH_GROUND, PH_READY, PH_LANDED: begin
        priority if (cmd_i == EV_PUBLISH) begin
          if (!has_ids) begin
            reason = R_ID_REQUIRED;
          end else begin
            acc       = 1'b1;
            phase_nxt = PH_READY;
            scope_nxt = SC_GROUND;
            tag_op    = TAG_LOAD;
          end
        end else if (cmd_i == EV_LAUNCH) begin
          reason = R_NOT_LOCKED;
        end else if (phase_i == PH_READY &&
                     (cmd_i == EV_WITHDRAW || cmd_i == EV_LOCK)) begin
          priority if (!both_match) begin
            reason = R_MISMATCH;
          end else if (cmd_i == EV_WITHDRAW) begin
            acc       = 1'b1;
            phase_nxt = PH_GROUND;
            scope_nxt = SC_GROUND;
            tag_op    = TAG_CLEAR;
          end else begin
            acc       = 1'b1;
            phase_nxt = PH_COMMITTED;
            scope_nxt = SC_BOUNDARY;
          end
        end else begin
          reason = (phase_i == PH_READY) ? R_BAD_IN_READY : R_BAD_IN_HOLD;
        end
      end
      PH_COMMITTED: begin
        priority if (cmd_i == EV_PUBLISH) begin
          reason = R_NO_REPLACE;
        end else if (cmd_i == EV_LAUNCH) begin
          if (!bnd_match) begin
            reason = R_MISMATCH;
          end else begin
            acc       = 1'b1;
            phase_nxt = PH_FLIGHT;
          end
        end else if (cmd_i == EV_INVALIDATE) begin
          acc       = 1'b1;
          phase_nxt = PH_EMERGENCY;
          scope_nxt = SC_EMERGENCY;
        end else begin
          reason = R_BAD_AFTER_LOCK;
        end
      end
      PH_FLIGHT: begin
        priority if (cmd_i == EV_LANDING) begin
          acc       = 1'b1;
          phase_nxt = PH_LANDED;
          scope_nxt = SC_GROUND;
          tag_op    = TAG_CLEAR;
        end else if (cmd_i == EV_INVALIDATE) begin
          acc       = 1'b1;
          phase_nxt = PH_EMERGENCY;
          scope_nxt = SC_EMERGENCY;
        end else begin
          reason = R_NO_REDIRECT;
        end
      end
      PH_EMERGENCY: begin
        reason = R_EMERGENCY;
      end
      default: begin
        // An unreachable phase code rejects everything and holds the state.
        reason = R_BAD_PHASE;
      end
    endcase
    if (acc) begin
      reason = R_ACCEPTED;
    end

    dec_o.res.accepted    = acc;
    dec_o.res.reason      = reason;
    dec_o.res.phase       = phase_nxt;
    dec_o.res.scope       = scope_nxt;
    dec_o.res.may_publish = (phase_nxt == PH_GROUND) || (phase_nxt == PH_READY) ||
                            (phase_nxt == PH_LANDED);
    dec_o.tag_op          = tag_op;
  end

endmodule

/* design/jci_checker.sv */
// ----------------------------------------------------------------------------
// Jump commitment interlock checker
// Port-level properties of the interlock, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "jump_commitment_interlock_fsm_defines.svh"

module jci_checker import jci_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  result_t res;

  assign res = out_tdata[RES_W-1:0];

  // A verdict and its reason code must agree.
  `JCI_ASSERT_NOW(a_verdict_reason, clk, rst_n, out_tvalid,
                  res.accepted == (res.reason == R_ACCEPTED),
                  "accepted flag disagrees with reason code")

  // The publish flag follows the reported phase.
  `JCI_ASSERT_NOW(a_may_publish, clk, rst_n, out_tvalid,
                  res.may_publish == (res.phase == PH_GROUND ||
                                      res.phase == PH_READY ||
                                      res.phase == PH_LANDED),
                  "may_publish disagrees with phase")

  // Emergency phase and emergency scope only ever appear together.
  `JCI_ASSERT_NOW(a_emergency_scope, clk, rst_n, out_tvalid,
                  (res.phase == PH_EMERGENCY) == (res.scope == SC_EMERGENCY),
                  "emergency phase and scope out of step")

  // A stalled result stays on offer unchanged.
  `JCI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata), "stalled result changed")

  // The input is only refused while a result is waiting, and that result stays.
  `JCI_ASSERT_NEXT(a_in_stall, clk, rst_n, in_tvalid && !in_tready,
                   out_tvalid, "input stalled with no result waiting")

endmodule

bind jump_commitment_interlock_fsm jci_checker u_jci_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
